// ===== rtl/core/face_corner_vertex_dedup_unit_assert.svh =====
// Assertion macros for the face corner vertex dedup unit.
// Used by the port checker; expects clk and arst_n in the including scope.
`ifndef FACE_CORNER_VERTEX_DEDUP_UNIT_ASSERT_SVH
`define FACE_CORNER_VERTEX_DEDUP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCVD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCVD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fcvd_pkg.sv =====
// Shared types and constants of the face corner vertex dedup unit.
// No dependencies; front end, queue, engine, top and checker use scoped names.
`timescale 1ns / 1ps
`default_nettype none
package fcvd_pkg;
	localparam int REF_W     = 22;
	localparam int IDX_W     = 20;
	localparam int CNT_W     = 21;
	localparam int MAX_ATTR  = 1 << IDX_W;
	localparam int TBL_DEPTH = 4096;
	localparam int SLOT_W    = 12;
	localparam int VTX_W     = 12;
	localparam int UNIQ_W    = 13;
	localparam logic [63:0] HASH_SEED = 64'd1469598103934665603;
	localparam logic [63:0] HASH_GOLD = 64'h9e3779b97f4a7c15;

	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_POS    = 3'd1,
		ACT_UV     = 3'd2,
		ACT_NRM    = 3'd3,
		ACT_CORNER = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_POS  = 3'd1,
		ST_UV   = 3'd2,
		ST_NRM  = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ERR,
		OP_LOOK
	} op_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MIXA,
		F_MIXB,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_ISSUE,
		B_LOOK,
		B_EMIT
	} back_state_t;

	// Resolved key; absent uv or normal carries a zero index.
	typedef struct packed {
		logic [IDX_W-1:0] p;
		logic             tp;
		logic [IDX_W-1:0] t;
		logic             np;
		logic [IDX_W-1:0] n;
	} key_t;

	typedef struct packed {
		op_t               op;
		status_t           status;
		logic [SLOT_W-1:0] home;
		key_t              key;
	} job_t;

	typedef struct packed {
		logic             valid;
		key_t             key;
		logic [VTX_W-1:0] vtx;
	} slot_t;

	typedef struct packed {
		status_t          status;
		logic [VTX_W-1:0] vtx;
		logic             is_new;
		key_t             key;
	} res_t;

	localparam int SLOT_BITS = $bits(slot_t);
	localparam int JOB_BITS  = $bits(job_t);
endpackage
`default_nettype wire

// ===== rtl/core/fcvd_if.sv =====
// Valid/ready channel interfaces for the corner input and the result output.
// Depends on nothing but the field widths of the block.
`timescale 1ns / 1ps
`default_nettype none
interface fcvd_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [21:0] pos_ref;
	logic signed [21:0] uv_ref;
	logic signed [21:0] normal_ref;
	modport source (output valid, action, pos_ref, uv_ref, normal_ref, input ready);
	modport sink (input valid, action, pos_ref, uv_ref, normal_ref, output ready);
endinterface

interface fcvd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] vertex_index;
	logic        is_new;
	logic [19:0] pos_index;
	logic        uv_present;
	logic [19:0] uv_index;
	logic        normal_present;
	logic [19:0] normal_index;
	modport source (output valid, status, vertex_index, is_new, pos_index, uv_present,
		uv_index, normal_present, normal_index, input ready);
	modport sink (input valid, status, vertex_index, is_new, pos_index, uv_present,
		uv_index, normal_present, normal_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fcvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fcvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/fcvd_front.sv =====
// Front end: accepts items, keeps the attribute counts, resolves references
// and computes the slot hash. Depends on fcvd_pkg and fcvd_if.
`timescale 1ns / 1ps
`default_nettype none
module fcvd_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      init_busy,
	fcvd_in_if.sink        corner,
	output logic           push,
	input  wire logic      q_full,
	output fcvd_pkg::job_t job
);
	typedef struct packed {
		logic                       ok;
		logic [fcvd_pkg::IDX_W-1:0] idx;
	} rs_t;

	function automatic rs_t resolve(input logic signed [21:0] rf,
			input logic [fcvd_pkg::CNT_W-1:0] cnt);
		logic signed [22:0] r;
		logic signed [22:0] c;
		rs_t o;
		c = $signed({2'b00, cnt});
		r = '0;
		o.ok = 1'b0;
		if (rf > 0) begin
			r = $signed({rf[21], rf}) - 23'sd1;
			o.ok = r < c;
		end else if (rf < 0) begin
			r = c + $signed({rf[21], rf});
			o.ok = !r[22];
		end
		o.idx = r[fcvd_pkg::IDX_W-1:0];
		return o;
	endfunction

	fcvd_pkg::front_state_t st_q, st_d;
	logic [1:0]                 mix_q;
	logic [63:0]                h_q, a_q, h_next, mix_x;
	logic [fcvd_pkg::CNT_W-1:0] pcnt_q, tcnt_q, ncnt_q;
	fcvd_pkg::job_t             job_q;
	fcvd_pkg::key_t             key_d;
	logic                       fire, corner_err;
	rs_t                        rp, rt, rn;

	assign fire = corner.valid && corner.ready;
	assign rp = resolve(corner.pos_ref, pcnt_q);
	assign rt = resolve(corner.uv_ref, tcnt_q);
	assign rn = resolve(corner.normal_ref, ncnt_q);
	assign corner_err = !rp.ok || (corner.uv_ref != 0 && !rt.ok)
		|| (corner.normal_ref != 0 && !rn.ok);
	assign h_next = h_q ^ (a_q + (h_q >> 2));
	assign job = job_q;

	// Resolved key of the item on the input; absent fields carry zero.
	always_comb begin
		key_d.p = rp.idx;
		key_d.tp = corner.uv_ref != 0;
		key_d.t = (corner.uv_ref != 0) ? rt.idx : '0;
		key_d.np = corner.normal_ref != 0;
		key_d.n = (corner.normal_ref != 0) ? rn.idx : '0;
	end

	always_comb begin
		case (mix_q)
			2'd0:    mix_x = {44'b0, job_q.key.p};
			2'd1:    mix_x = job_q.key.tp ? {44'b0, job_q.key.t} : '1;
			default: mix_x = job_q.key.np ? {44'b0, job_q.key.n} : '1;
		endcase
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			fcvd_pkg::F_IDLE: begin
				if (fire) begin
					if (corner.action == fcvd_pkg::ACT_CLEAR) begin
						st_d = fcvd_pkg::F_PUSH;
					end else if (corner.action == fcvd_pkg::ACT_CORNER) begin
						st_d = corner_err ? fcvd_pkg::F_PUSH : fcvd_pkg::F_MIXA;
					end
				end
			end
			fcvd_pkg::F_MIXA: st_d = fcvd_pkg::F_MIXB;
			fcvd_pkg::F_MIXB: st_d = (mix_q == 2'd2) ? fcvd_pkg::F_PUSH : fcvd_pkg::F_MIXA;
			fcvd_pkg::F_PUSH: if (!q_full) st_d = fcvd_pkg::F_IDLE;
			default: st_d = fcvd_pkg::F_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		corner.ready = 1'b0;
		push = 1'b0;
		case (st_q)
			fcvd_pkg::F_IDLE: corner.ready = !init_busy;
			fcvd_pkg::F_PUSH: push = !q_full;
			default: begin
				corner.ready = 1'b0;
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fcvd_pkg::F_IDLE;
			pcnt_q <= '0;
			tcnt_q <= '0;
			ncnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (fire) begin
				case (corner.action)
					fcvd_pkg::ACT_CLEAR: begin
						pcnt_q <= '0;
						tcnt_q <= '0;
						ncnt_q <= '0;
					end
					fcvd_pkg::ACT_POS:
						if (pcnt_q != fcvd_pkg::CNT_W'(fcvd_pkg::MAX_ATTR)) pcnt_q <= pcnt_q + 1'b1;
					fcvd_pkg::ACT_UV:
						if (tcnt_q != fcvd_pkg::CNT_W'(fcvd_pkg::MAX_ATTR)) tcnt_q <= tcnt_q + 1'b1;
					fcvd_pkg::ACT_NRM:
						if (ncnt_q != fcvd_pkg::CNT_W'(fcvd_pkg::MAX_ATTR)) ncnt_q <= ncnt_q + 1'b1;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			job_q.home <= '0;
			h_q <= fcvd_pkg::HASH_SEED;
			mix_q <= 2'd0;
			if (corner.action == fcvd_pkg::ACT_CLEAR) begin
				job_q.op <= fcvd_pkg::OP_CLEAR;
				job_q.status <= fcvd_pkg::ST_OK;
				job_q.key <= '0;
			end else if (corner_err) begin
				// The first failing check wins: position, then uv, then normal.
				job_q.op <= fcvd_pkg::OP_ERR;
				job_q.key <= '0;
				if (!rp.ok) job_q.status <= fcvd_pkg::ST_POS;
				else if (corner.uv_ref != 0 && !rt.ok) job_q.status <= fcvd_pkg::ST_UV;
				else job_q.status <= fcvd_pkg::ST_NRM;
			end else begin
				job_q.op <= fcvd_pkg::OP_LOOK;
				job_q.status <= fcvd_pkg::ST_OK;
				job_q.key <= key_d;
			end
		end else if (st_q == fcvd_pkg::F_MIXA) begin
			a_q <= mix_x + fcvd_pkg::HASH_GOLD + (h_q << 6);
		end else if (st_q == fcvd_pkg::F_MIXB) begin
			h_q <= h_next;
			mix_q <= mix_q + 2'd1;
			job_q.home <= h_next[fcvd_pkg::SLOT_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/fcvd_queue.sv =====
// Two-entry job queue between the front end and the table engine.
// Depends on fcvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcvd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fcvd_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output fcvd_pkg::job_t      head
);
	fcvd_pkg::job_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) ent_q[wp_q] <= push_job;
	end
endmodule
`default_nettype wire

// ===== rtl/core/fcvd_back.sv =====
// Table engine: clears the slot memory, probes it linearly and holds the
// result register. Depends on fcvd_pkg and fcvd_ram.
`timescale 1ns / 1ps
`default_nettype none
module fcvd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire fcvd_pkg::job_t head,
	output logic                pop,
	output logic                init_busy,
	output logic                res_valid,
	input  wire logic           res_ready,
	output fcvd_pkg::res_t      res
);
	fcvd_pkg::back_state_t st_q, st_d;
	fcvd_pkg::job_t              job_q;
	fcvd_pkg::res_t              pend_q, res_q, pend_init;
	fcvd_pkg::slot_t             rd_slot, wr_slot;
	logic [fcvd_pkg::SLOT_BITS-1:0] rdata;
	logic [fcvd_pkg::SLOT_W-1:0] slot_q, clr_q, probe_q, waddr;
	logic [fcvd_pkg::UNIQ_W-1:0] uniq_q;
	logic                        init_q, out_q, we, out_free, hit, last_probe, clr_last;

	assign rd_slot = fcvd_pkg::slot_t'(rdata);
	assign hit = rd_slot.valid && rd_slot.key == job_q.key;
	assign last_probe = probe_q == fcvd_pkg::SLOT_W'(fcvd_pkg::TBL_DEPTH - 1);
	assign clr_last = clr_q == fcvd_pkg::SLOT_W'(fcvd_pkg::TBL_DEPTH - 1);
	assign out_free = !out_q || res_ready;
	assign init_busy = init_q;
	assign res_valid = out_q;
	assign res = res_q;

	// A job starts with every result field zero but its status.
	always_comb begin
		pend_init = '0;
		pend_init.status = head.status;
	end

	fcvd_ram #(
		.WIDTH(fcvd_pkg::SLOT_BITS),
		.DEPTH(fcvd_pkg::TBL_DEPTH)
	) u_slots (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wr_slot),
		.raddr(slot_q),
		.rdata(rdata)
	);

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			fcvd_pkg::B_CLEAR: if (clr_last) st_d = fcvd_pkg::B_IDLE;
			fcvd_pkg::B_IDLE: begin
				if (!q_empty) begin
					case (head.op)
						fcvd_pkg::OP_CLEAR: st_d = fcvd_pkg::B_CLEAR;
						fcvd_pkg::OP_LOOK:  st_d = fcvd_pkg::B_ISSUE;
						default:            st_d = fcvd_pkg::B_EMIT;
					endcase
				end
			end
			fcvd_pkg::B_ISSUE: st_d = fcvd_pkg::B_LOOK;
			fcvd_pkg::B_LOOK: begin
				if (!rd_slot.valid || hit || last_probe) st_d = fcvd_pkg::B_EMIT;
				else st_d = fcvd_pkg::B_ISSUE;
			end
			fcvd_pkg::B_EMIT: if (out_free) st_d = fcvd_pkg::B_IDLE;
			default: st_d = fcvd_pkg::B_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		pop = 1'b0;
		we = 1'b0;
		waddr = slot_q;
		wr_slot.valid = 1'b1;
		wr_slot.key = job_q.key;
		wr_slot.vtx = uniq_q[fcvd_pkg::VTX_W-1:0];
		case (st_q)
			fcvd_pkg::B_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wr_slot = '0;
			end
			fcvd_pkg::B_IDLE: pop = !q_empty;
			fcvd_pkg::B_LOOK: we = !rd_slot.valid;
			default: begin
				pop = 1'b0;
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fcvd_pkg::B_CLEAR;
			init_q <= 1'b1;
			clr_q <= '0;
			uniq_q <= '0;
			out_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == fcvd_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_last) init_q <= 1'b0;
			end
			if (st_q == fcvd_pkg::B_IDLE && !q_empty && head.op == fcvd_pkg::OP_CLEAR) begin
				clr_q <= '0;
				uniq_q <= '0;
			end
			if (st_q == fcvd_pkg::B_LOOK && !rd_slot.valid) uniq_q <= uniq_q + 1'b1;
			if (st_q == fcvd_pkg::B_EMIT && out_free) out_q <= 1'b1;
			else if (res_ready) out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == fcvd_pkg::B_IDLE && !q_empty) begin
			job_q <= head;
			slot_q <= head.home;
			probe_q <= '0;
			pend_q <= pend_init;
		end
		if (st_q == fcvd_pkg::B_LOOK) begin
			if (!rd_slot.valid) begin
				pend_q.status <= fcvd_pkg::ST_OK;
				pend_q.vtx <= uniq_q[fcvd_pkg::VTX_W-1:0];
				pend_q.is_new <= 1'b1;
				pend_q.key <= job_q.key;
			end else if (hit) begin
				pend_q.status <= fcvd_pkg::ST_OK;
				pend_q.vtx <= rd_slot.vtx;
				pend_q.is_new <= 1'b0;
				pend_q.key <= job_q.key;
			end else if (last_probe) begin
				pend_q.status <= fcvd_pkg::ST_FULL;
			end else begin
				slot_q <= slot_q + 1'b1;
				probe_q <= probe_q + 1'b1;
			end
		end
		if (st_q == fcvd_pkg::B_EMIT && out_free) res_q <= pend_q;
	end
endmodule
`default_nettype wire

// ===== rtl/core/face_corner_vertex_dedup_unit.sv =====
// Top level of the face corner vertex dedup unit.
// Depends on fcvd_pkg, fcvd_if, fcvd_front, fcvd_queue and fcvd_back.
//
// Channel corner takes one item per valid/ready handshake: a start-of-mesh
// clear, a position, uv or normal record, or a face corner. Channel result
// returns one item for each face corner and nothing for the other actions.
// The front takes records without leaving its idle state. A corner is resolved
// as it is taken, then passes three hash mixes, each through F_MIXA and F_MIXB,
// and the queue push; a corner that fails to resolve goes straight to the push.
// The front takes no new item until that push. The table engine picks up the
// job, takes B_ISSUE and B_LOOK per probe of the synchronous slot memory and
// loads the result register in B_EMIT; long probe chains can fill the queue.
// After reset, and after every start-of-mesh item, the engine clears all 4096
// entries of the slot memory. During the clearing pass after reset the
// corner channel is not ready; a later clear only delays the queued work.
// When the receiver stalls, the result register holds, the engine waits, the
// two-entry queue fills and then the corner channel deasserts ready.
`timescale 1ns / 1ps
`default_nettype none
module face_corner_vertex_dedup_unit (
	input wire logic clk,
	input wire logic arst_n,
	fcvd_in_if.sink  corner,
	fcvd_out_if.source result
);
	fcvd_pkg::job_t front_job, head;
	fcvd_pkg::res_t res;
	logic           push, q_full, q_empty, pop, init_busy;

	fcvd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.init_busy(init_busy),
		.corner(corner),
		.push(push),
		.q_full(q_full),
		.job(front_job)
	);

	fcvd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(front_job),
		.full(q_full),
		.pop(pop),
		.empty(q_empty),
		.head(head)
	);

	fcvd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.init_busy(init_busy),
		.res_valid(result.valid),
		.res_ready(result.ready),
		.res(res)
	);

	assign result.status = res.status;
	assign result.vertex_index = res.vtx;
	assign result.is_new = res.is_new;
	assign result.pos_index = res.key.p;
	assign result.uv_present = res.key.tp;
	assign result.uv_index = res.key.t;
	assign result.normal_present = res.key.np;
	assign result.normal_index = res.key.n;
endmodule
`default_nettype wire

// ===== rtl/core/fcvd_checker.sv =====
// Port-level checker of the face corner vertex dedup unit, bound to the top.
// Depends on fcvd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "face_corner_vertex_dedup_unit_assert.svh"
module fcvd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic        is_new,
	input wire logic [11:0] vertex_index,
	input wire logic [19:0] pos_index,
	input wire logic        uv_present,
	input wire logic [19:0] uv_index,
	input wire logic        normal_present,
	input wire logic [19:0] normal_index
);
	logic err_item, fields_zero;

	assign err_item = out_valid && status != fcvd_pkg::ST_OK;
	assign fields_zero = vertex_index == 0 && !is_new && pos_index == 0 && !uv_present
		&& uv_index == 0 && !normal_present && normal_index == 0;

	`FCVD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped while stalled")
	`FCVD_ASSERT_IMP(a_err_zero, err_item, fields_zero, "error item carries nonzero fields")
	`FCVD_ASSERT_IMP(a_uv_abs, out_valid && !uv_present, uv_index == 0, "absent uv with index")
	`FCVD_ASSERT_IMP(a_nrm_abs, out_valid && !normal_present, normal_index == 0, "absent normal with index")
endmodule

bind face_corner_vertex_dedup_unit fcvd_checker u_fcvd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.status(result.status),
	.is_new(result.is_new),
	.vertex_index(result.vertex_index),
	.pos_index(result.pos_index),
	.uv_present(result.uv_present),
	.uv_index(result.uv_index),
	.normal_present(result.normal_present),
	.normal_index(result.normal_index)
);
`default_nettype wire

// ===== tb/face_corner_vertex_dedup_unit_test.sv =====
// Testbench of the face corner vertex dedup unit: random and directed mesh streams.
// Depends on fcvd_pkg, fcvd_if and the block top; predicts every corner result itself.
`timescale 1ns / 1ps
module face_corner_vertex_dedup_unit_test;
	import fcvd_pkg::*;

	localparam int STALL_LIMIT = 40000;

	typedef struct {
		logic [2:0]   action;
		logic [21:0]  pos_ref;
		logic [21:0]  uv_ref;
		logic [21:0]  normal_ref;
		bit           drain;
	} mesh_item_t;

	typedef struct {
		status_t      status;
		logic [11:0]  vertex_index;
		logic         is_new;
		logic [19:0]  pos_index;
		logic         uv_present;
		logic [19:0]  uv_index;
		logic         normal_present;
		logic [19:0]  normal_index;
	} corner_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	fcvd_in_if cin();
	fcvd_out_if rout();

	face_corner_vertex_dedup_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.corner(cin),
		.result(rout)
	);

	mesh_item_t pending_items[$];
	corner_result_t expected_results[$];
	int failures = 0;
	int results_seen = 0;

	// Shadow of the block state.
	int unsigned n_pos, n_uv, n_nrm, n_unique;
	bit slot_used[TBL_DEPTH];
	longint slot_p[TBL_DEPTH], slot_uv[TBL_DEPTH], slot_n[TBL_DEPTH];
	int unsigned slot_vtx[TBL_DEPTH];

	function automatic void clear_mesh();
		n_pos = 0;
		n_uv = 0;
		n_nrm = 0;
		n_unique = 0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			slot_used[i] = 1'b0;
		end
	endfunction

	// Returns -1 when the reference names no index below count.
	function automatic longint resolve_ref(logic signed [21:0] r, int unsigned count);
		longint v;
		v = longint'(r);
		if (v > 0)
			v = v - 1;
		else if (v < 0)
			v = longint'(count) + v;
		else
			return -1;
		if (v < 0 || v >= longint'(count))
			return -1;
		return v;
	endfunction

	function automatic logic [63:0] hash_mix(logic [63:0] h, longint x);
		return h ^ (64'(x) + HASH_GOLD + (h << 6) + (h >> 2));
	endfunction

	function automatic void predict_item(mesh_item_t it);
		corner_result_t res;
		longint p, t, n;
		bit has_t, has_n, placed;
		logic [63:0] h;
		int unsigned s;
		res = '{ST_OK, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0};
		case (it.action)
			ACT_CLEAR: begin
				clear_mesh();
				return;
			end
			ACT_POS: begin
				if (n_pos < MAX_ATTR) n_pos++;
				return;
			end
			ACT_UV: begin
				if (n_uv < MAX_ATTR) n_uv++;
				return;
			end
			ACT_NRM: begin
				if (n_nrm < MAX_ATTR) n_nrm++;
				return;
			end
			ACT_CORNER: ;
			default: return;
		endcase
		has_t = it.uv_ref != 0;
		has_n = it.normal_ref != 0;
		p = resolve_ref(it.pos_ref, n_pos);
		t = has_t ? resolve_ref(it.uv_ref, n_uv) : -1;
		n = has_n ? resolve_ref(it.normal_ref, n_nrm) : -1;
		if (p < 0)
			res.status = ST_POS;
		else if (has_t && t < 0)
			res.status = ST_UV;
		else if (has_n && n < 0)
			res.status = ST_NRM;
		else begin
			h = hash_mix(hash_mix(hash_mix(HASH_SEED, p), t), n);
			s = h % TBL_DEPTH;
			placed = 1'b0;
			for (int k = 0; k < TBL_DEPTH && !placed; k++) begin
				if (!slot_used[s]) begin
					slot_used[s] = 1'b1;
					slot_p[s] = p;
					slot_uv[s] = t;
					slot_n[s] = n;
					slot_vtx[s] = n_unique;
					res.vertex_index = n_unique[11:0];
					res.is_new = 1'b1;
					n_unique++;
					placed = 1'b1;
				end else if (slot_p[s] == p && slot_uv[s] == t && slot_n[s] == n) begin
					res.vertex_index = slot_vtx[s][11:0];
					placed = 1'b1;
				end else
					s = (s + 1) % TBL_DEPTH;
			end
			if (!placed) begin
				res.status = ST_FULL;
				res.vertex_index = '0;
			end else begin
				res.pos_index = p[19:0];
				res.uv_present = has_t;
				res.uv_index = has_t ? t[19:0] : '0;
				res.normal_present = has_n;
				res.normal_index = has_n ? n[19:0] : '0;
			end
		end
		expected_results.insert(expected_results.size(), res);
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endfunction

	task automatic queue_item(logic [2:0] act, int pr = 0, int ur = 0, int nr = 0,
		bit drain = 1'b0);
		pending_items.insert(pending_items.size(), '{act, 22'(pr), 22'(ur), 22'(nr), drain});
	endtask

	// Mostly a valid reference, sometimes absent, past the end or raw noise.
	function automatic int pick_ref(int unsigned count, bit may_omit);
		int sel;
		sel = $urandom_range(0, 99);
		if (may_omit && sel < 15)
			return 0;
		if (count > 0 && sel < 70)
			return $urandom_range(1, count);
		if (count > 0 && sel < 88)
			return -int'($urandom_range(1, count));
		if (sel < 94)
			return sel[0] ? int'(count) + $urandom_range(1, 3) : -int'(count) - 1;
		return $signed(22'($urandom));
	endfunction

	// Sender: bursts of random length separated by random gaps.
	mesh_item_t cur_item;
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cin.valid <= 1'b0;
			cin.action <= '0;
			cin.pos_ref <= '0;
			cin.uv_ref <= '0;
			cin.normal_ref <= '0;
		end else if (!cin.valid || cin.ready) begin
			if (cin.valid)
				predict_item(cur_item);
			if (gap_left > 0) begin
				gap_left--;
				cin.valid <= 1'b0;
			end else if (pending_items.size() > 0 &&
				!(pending_items[0].drain && expected_results.size() > 0)) begin
				cur_item = pending_items.pop_front();
				cin.valid <= 1'b1;
				cin.action <= cur_item.action;
				cin.pos_ref <= cur_item.pos_ref;
				cin.uv_ref <= cur_item.uv_ref;
				cin.normal_ref <= cur_item.normal_ref;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else
				cin.valid <= 1'b0;
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off.
	int ready_left = 0;
	int stall_left = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rout.ready <= 1'b0;
		end else begin
			if (rout.valid && rout.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result item arrived with nothing expected");
					failures++;
				end else begin
					corner_result_t e;
					e = expected_results.pop_front();
					check_field("status", e.status, rout.status);
					check_field("vertex_index", e.vertex_index, rout.vertex_index);
					check_field("is_new", e.is_new, rout.is_new);
					check_field("pos_index", e.pos_index, rout.pos_index);
					check_field("uv_present", e.uv_present, rout.uv_present);
					check_field("uv_index", e.uv_index, rout.uv_index);
					check_field("normal_present", e.normal_present, rout.normal_present);
					check_field("normal_index", e.normal_index, rout.normal_index);
				end
			end
			if (!long_hold_done && results_seen >= 300) begin
				long_hold_done = 1'b1;
				stall_left = 600;
				ready_left = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				rout.ready <= 1'b0;
			end else if (ready_left > 0) begin
				ready_left--;
				rout.ready <= 1'b1;
			end else begin
				ready_left = $urandom_range(1, 30);
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				rout.ready <= 1'b1;
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((cin.valid && cin.ready) || (rout.valid && rout.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("face_corner_vertex_dedup_unit_test NOT OK");
			$finish;
		end
	end

	initial begin
		int queued;
		int n_p, n_u, n_n;
		clear_mesh();
		// Directed: errors on an empty mesh, then every resolution rule and unused actions.
		queue_item(ACT_CLEAR);
		queue_item(ACT_CORNER, 1, 0, 0);
		queue_item(ACT_CORNER, 0, 0, 0);
		repeat (3) queue_item(ACT_POS);
		repeat (2) queue_item(ACT_UV);
		repeat (2) queue_item(ACT_NRM);
		queue_item(ACT_CORNER, 1, 0, 0);
		queue_item(ACT_CORNER, -3, 0, 0);
		queue_item(ACT_CORNER, 3, 2, -1);
		queue_item(ACT_CORNER, -1, -1, 2);
		queue_item(ACT_CORNER, 4, 1, 1);
		queue_item(ACT_CORNER, -4, 1, 1);
		queue_item(ACT_CORNER, 1, 3, 5);
		queue_item(ACT_CORNER, 1, -3, 1);
		queue_item(ACT_CORNER, 2, 1, 3);
		queue_item(ACT_CORNER, 2, 1, -3);
		queue_item(ACT_CORNER, 1048576, -1048576, 0);
		queue_item(ACT_CORNER, 2, 2097151, -2097152);
		queue_item(ACT_CORNER, -2097152, 1, 1);
		queue_item(3'd5, 1, 1, 1);
		queue_item(3'd6);
		queue_item(3'd7, -1, -1, -1);
		queue_item(ACT_CORNER, 1, 0, 0, 1'b1);
		queued = 0;
		// Random meshes: records first, then mostly corners that revisit earlier keys.
		while (queued < 1700) begin
			queue_item(ACT_CLEAR);
			n_p = $urandom_range(1, 60);
			n_u = $urandom_range(0, 30);
			n_n = $urandom_range(0, 30);
			if ($urandom_range(0, 5) == 0) n_p = $urandom_range(200, 400);
			repeat (n_p) queue_item(ACT_POS);
			repeat (n_u) queue_item(ACT_UV);
			repeat (n_n) queue_item(ACT_NRM);
			queued += n_p + n_u + n_n + 1;
			for (int i = $urandom_range(80, 300); i > 0; i--) begin
				int sel;
				sel = $urandom_range(0, 99);
				if (sel < 85)
					queue_item(ACT_CORNER, pick_ref(n_p, 1'b0), pick_ref(n_u, 1'b1),
						pick_ref(n_n, 1'b1), queued > 800 && queued < 1000 && i == 1);
				else if (sel < 90)
					queue_item(ACT_POS);
				else if (sel < 94)
					queue_item(ACT_UV);
				else if (sel < 98)
					queue_item(ACT_NRM);
				else
					queue_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
				queued++;
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending_items.size() > 0 || cin.valid || expected_results.size() > 0);
		repeat (100) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0)
			$display("face_corner_vertex_dedup_unit_test OK");
		else
			$display("face_corner_vertex_dedup_unit_test NOT OK");
		$finish;
	end
endmodule
